### hdl/spq_pkg.sv
// Package for the sprite quad batcher: payload structs, register indexes,
// internal request/response structs and the 32-bit saturation helper.
// No dependencies.
package spq_pkg;

  localparam int unsigned MAX_TEXTURES_DEF = 32;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_Z = 3'd5;

  localparam logic [47:0] ROW_X_RST = 48'h0000_0000_1000;
  localparam logic [47:0] ROW_Y_RST = 48'h0000_1000_0000;
  localparam logic [47:0] ROW_Z_RST = 48'h1000_0000_0000;

  localparam logic [19:0] IDX_STEP = 20'd6;
  localparam logic [19:0] IDX_MAX  = 20'hFFFFF;

  localparam logic signed [39:0] SAT_HI = 40'sd2147483647;
  localparam logic signed [39:0] SAT_LO = -40'sd2147483648;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] size_w;
    logic signed [31:0] size_h;
    logic [31:0]        colour_in;
    logic [31:0]        texture_id;
    logic [63:0]        uv_first;
    logic [63:0]        uv_second;
  } spq_in_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [5:0]         tex_slot;
    logic [31:0]        colour_out;
    logic               flush_batch;
    logic [19:0]        flushed_indices;
    logic               last;
  } spq_out_t;

  // transform unit request / response
  typedef struct packed {
    logic               start;
    logic [47:0]        row;
    logic signed [31:0] trans;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } spq_xf_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] value;
  } spq_xf_res_t;

  // slot table request / response
  typedef struct packed {
    logic        start;
    logic        clear;
    logic [31:0] tid;
  } spq_slot_req_t;

  typedef struct packed {
    logic       done;
    logic [5:0] slot;
    logic       flush;
  } spq_slot_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    return (v > SAT_HI) ? 32'sh7FFFFFFF :
           (v < SAT_LO) ? 32'sh80000000 : v[31:0];
  endfunction

endpackage

### hdl/spq_if.sv
// Valid/ready channel interfaces for sprite input and vertex output.
// Depends on spq_pkg for the payload structs.
interface spq_in_if;
  logic            valid;
  logic            ready;
  spq_pkg::spq_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface spq_out_if;
  logic             valid;
  logic             ready;
  spq_pkg::spq_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/spq_xform.sv
// Shared transform unit: one 16x32 multiplier reused for the three terms of
// a matrix row, then rounding and saturating translation. Depends on spq_pkg.
module spq_xform (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::spq_xf_req_t req_i,
  output spq_pkg::spq_xf_res_t res_o
);

  typedef enum logic [2:0] {X_IDLE, X_MUL, X_ACC, X_RND, X_FIN} xf_state_e;

  xf_state_e          state_q;
  logic [1:0]         cnt_q;
  logic signed [47:0] prod_q;
  logic signed [50:0] acc_q;
  logic signed [38:0] rnd_q;
  logic signed [31:0] res_q;
  logic               done_q;

  logic signed [15:0] coef;
  logic signed [31:0] oper;
  logic signed [47:0] prod;
  logic signed [50:0] acc_add;
  logic signed [50:0] rnd_sum;
  logic signed [39:0] fin_sum;

  always_comb begin
    case (cnt_q)
      2'd0:    begin coef = req_i.row[15:0];  oper = req_i.px; end
      2'd1:    begin coef = req_i.row[31:16]; oper = req_i.py; end
      default: begin coef = req_i.row[47:32]; oper = req_i.pz; end
    endcase
  end

  assign prod    = coef * oper;
  assign acc_add = acc_q + $signed({{3{prod_q[47]}}, prod_q});
  // round to nearest, ties up: add half an LSB then floor
  assign rnd_sum = acc_q + 51'sd2048;
  assign fin_sum = $signed({rnd_q[38], rnd_q}) + $signed({{8{req_i.trans[31]}}, req_i.trans});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= X_IDLE;
      cnt_q   <= 2'd0;
      prod_q  <= '0;
      acc_q   <= '0;
      rnd_q   <= '0;
      res_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == X_FIN);
      case (state_q)
        X_IDLE: begin
          if (req_i.start) begin
            cnt_q   <= 2'd0;
            acc_q   <= '0;
            state_q <= X_MUL;
          end
        end
        X_MUL: begin
          prod_q <= prod;
          if (cnt_q != 2'd0) acc_q <= acc_add;
          if (cnt_q == 2'd2) begin
            state_q <= X_ACC;
          end else begin
            cnt_q <= cnt_q + 2'd1;
          end
        end
        X_ACC: begin
          acc_q   <= acc_add;
          state_q <= X_RND;
        end
        X_RND: begin
          rnd_q   <= rnd_sum[50:12];
          state_q <= X_FIN;
        end
        X_FIN: begin
          res_q   <= spq_pkg::sat32(fin_sum);
          state_q <= X_IDLE;
        end
        default: state_q <= X_IDLE;
      endcase
    end
  end

  assign res_o.done  = done_q;
  assign res_o.value = res_q;

endmodule

### hdl/spq_slot_table.sv
// Texture slot table: memory of texture ids searched one entry per cycle,
// append on miss, wrap-around flush when full. Depends on spq_pkg.
module spq_slot_table #(
  parameter int unsigned MAX_TEXTURES = spq_pkg::MAX_TEXTURES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  spq_pkg::spq_slot_req_t req_i,
  output spq_pkg::spq_slot_res_t res_o
);

  localparam int unsigned IW = (MAX_TEXTURES > 1) ? $clog2(MAX_TEXTURES) : 1;
  localparam int unsigned SW = $clog2(MAX_TEXTURES + 1);
  localparam logic [SW-1:0] MAX_CNT = SW'(MAX_TEXTURES);

  typedef enum logic {T_IDLE, T_SEARCH} slot_state_e;

  slot_state_e     state_q;
  logic [31:0]     slot_mem_q [MAX_TEXTURES];
  logic [31:0]     rdata_q;
  logic [31:0]     tid_q;
  logic [SW-1:0]   used_q;
  logic [SW-1:0]   addr_q;
  logic            cmp_v_q;
  logic [IW-1:0]   cmp_idx_q;
  logic            done_q;
  logic [5:0]      slot_q;
  logic            flush_q;

  logic            hit;
  logic            more;
  logic            wr_en;
  logic [IW-1:0]   wr_idx;
  logic            full;

  assign hit    = cmp_v_q && (rdata_q == tid_q);
  assign more   = addr_q < used_q;
  assign full   = used_q >= MAX_CNT;
  assign wr_en  = (state_q == T_SEARCH) && !hit && !more;
  assign wr_idx = full ? '0 : used_q[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) slot_mem_q[wr_idx] <= tid_q;
    rdata_q <= slot_mem_q[addr_q[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= T_IDLE;
      tid_q     <= '0;
      used_q    <= '0;
      addr_q    <= '0;
      cmp_v_q   <= 1'b0;
      cmp_idx_q <= '0;
      done_q    <= 1'b0;
      slot_q    <= '0;
      flush_q   <= 1'b0;
    end else begin
      done_q <= (state_q == T_SEARCH) && (hit || !more);
      case (state_q)
        T_IDLE: begin
          if (req_i.clear) used_q <= '0;
          if (req_i.start) begin
            tid_q   <= req_i.tid;
            addr_q  <= '0;
            cmp_v_q <= 1'b0;
            state_q <= T_SEARCH;
          end
        end
        T_SEARCH: begin
          if (hit) begin
            flush_q <= 1'b0;
            slot_q  <= 6'((SW+1)'(cmp_idx_q) + (SW+1)'(1));
            state_q <= T_IDLE;
          end else if (more) begin
            cmp_v_q   <= 1'b1;
            cmp_idx_q <= addr_q[IW-1:0];
            addr_q    <= addr_q + SW'(1);
          end else begin
            // miss: append, restarting the batch if the table is full
            state_q <= T_IDLE;
            if (full) begin
              flush_q <= 1'b1;
              used_q  <= SW'(1);
              slot_q  <= 6'd1;
            end else begin
              flush_q <= 1'b0;
              used_q  <= used_q + SW'(1);
              slot_q  <= 6'((SW+1)'(used_q) + (SW+1)'(1));
            end
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign res_o.done  = done_q;
  assign res_o.slot  = slot_q;
  assign res_o.flush = flush_q;

endmodule

### hdl/sprite_quad_batcher.sv
// Sprite quad batcher top level. An untextured sprite is worked as 4 vertices,
// each three passes through the shared multiply unit plus an emit step; the
// next transaction is taken once the sequencer is back in idle. A textured
// sprite first searches the slots in use; a flush item goes straight to its
// emit step. Vertex back-pressure stalls the emit step.
// Async active-low reset: matrix = identity, translation 0, batch empty.
module sprite_quad_batcher #(
  parameter int unsigned MAX_TEXTURES = spq_pkg::MAX_TEXTURES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  spq_in_if.sink                              sprite_i,
  spq_out_if.source                           vert_o,
  input  logic                                cfg_we_i,
  input  logic [spq_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [spq_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_XFORM, S_EMIT} top_state_e;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [47:0]        row_x_q, row_y_q, row_z_q;
  logic signed [31:0] trans_x_q, trans_y_q, trans_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_x_q   <= spq_pkg::ROW_X_RST;
      row_y_q   <= spq_pkg::ROW_Y_RST;
      row_z_q   <= spq_pkg::ROW_Z_RST;
      trans_x_q <= '0;
      trans_y_q <= '0;
      trans_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spq_pkg::CFG_ROW_X:   row_x_q   <= cfg_data_i[47:0];
        spq_pkg::CFG_ROW_Y:   row_y_q   <= cfg_data_i[47:0];
        spq_pkg::CFG_ROW_Z:   row_z_q   <= cfg_data_i[47:0];
        spq_pkg::CFG_TRANS_X: trans_x_q <= cfg_data_i[31:0];
        spq_pkg::CFG_TRANS_Y: trans_y_q <= cfg_data_i[31:0];
        spq_pkg::CFG_TRANS_Z: trans_z_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer state and latched sprite
  // ---------------------------------------------------------------------
  top_state_e         state_q;
  logic signed [31:0] px_q, py_q, pz_q, x1_q, y1_q;
  logic [31:0]        colour_q;
  logic [63:0]        uv_a_q, uv_b_q;
  logic [5:0]         slot_q;
  logic               flush_item_q;   // current transaction is a flush item
  logic               flush_q;        // batch flushed ahead of this item
  logic [19:0]        flushed_q;
  logic [19:0]        index_total_q;
  logic [1:0]         k_q;            // corner 0..3
  logic [1:0]         o_q;            // output component x/y/z
  logic               launched_q;
  logic signed [31:0] vx_q, vy_q, vz_q;
  logic               out_valid_q;
  spq_pkg::spq_out_t  out_q;

  spq_pkg::spq_xf_req_t   xf_req;
  spq_pkg::spq_xf_res_t   xf_res;
  spq_pkg::spq_slot_req_t slot_req;
  spq_pkg::spq_slot_res_t slot_res;

  logic               in_acc;
  logic               out_free;
  logic               emit_go;
  logic signed [39:0] x1_sum, y1_sum;
  logic [31:0]        uv_sel;
  spq_pkg::spq_out_t  emit_data;

  assign sprite_i.ready = (state_q == S_IDLE);
  assign in_acc         = sprite_i.valid && sprite_i.ready;
  assign out_free       = !out_valid_q || vert_o.ready;
  assign emit_go        = (state_q == S_EMIT) && out_free;

  // far corner sums, saturated to 32 bits
  assign x1_sum = $signed({{8{sprite_i.data.pos_x[31]}}, sprite_i.data.pos_x})
                + $signed({{8{sprite_i.data.size_w[31]}}, sprite_i.data.size_w});
  assign y1_sum = $signed({{8{sprite_i.data.pos_y[31]}}, sprite_i.data.pos_y})
                + $signed({{8{sprite_i.data.size_h[31]}}, sprite_i.data.size_h});

  // slot search kicks off straight from the accepted transaction
  assign slot_req.start = in_acc && !sprite_i.data.mode && (sprite_i.data.texture_id != '0);
  assign slot_req.clear = in_acc && sprite_i.data.mode;
  assign slot_req.tid   = sprite_i.data.texture_id;

  // Corner order: (x,y) (x,y+h) (x+w,y+h) (x+w,y)
  always_comb begin
    xf_req.start = (state_q == S_XFORM) && !launched_q;
    xf_req.px    = k_q[1] ? x1_q : px_q;
    xf_req.py    = (k_q[0] ^ k_q[1]) ? y1_q : py_q;
    xf_req.pz    = pz_q;
    case (o_q)
      2'd0:    begin xf_req.row = row_x_q; xf_req.trans = trans_x_q; end
      2'd1:    begin xf_req.row = row_y_q; xf_req.trans = trans_y_q; end
      default: begin xf_req.row = row_z_q; xf_req.trans = trans_z_q; end
    endcase
  end

  always_comb begin
    case (k_q)
      2'd0:    uv_sel = uv_a_q[31:0];
      2'd1:    uv_sel = uv_a_q[63:32];
      2'd2:    uv_sel = uv_b_q[31:0];
      default: uv_sel = uv_b_q[63:32];
    endcase
  end

  // Result transaction for the current step; flush items carry only the count and the flush and last flags
  always_comb begin
    emit_data = '0;
    if (flush_item_q) begin
      emit_data.flush_batch     = 1'b1;
      emit_data.flushed_indices = flushed_q;
      emit_data.last            = 1'b1;
    end else begin
      emit_data.vert_x          = vx_q;
      emit_data.vert_y          = vy_q;
      emit_data.vert_z          = vz_q;
      emit_data.tex_u           = uv_sel[15:0];
      emit_data.tex_v           = uv_sel[31:16];
      emit_data.tex_slot        = slot_q;
      emit_data.colour_out      = colour_q;
      emit_data.flush_batch     = (k_q == 2'd0) && flush_q;
      emit_data.flushed_indices = ((k_q == 2'd0) && flush_q) ? flushed_q : '0;
      emit_data.last            = (k_q == 2'd3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      px_q          <= '0;
      py_q          <= '0;
      pz_q          <= '0;
      x1_q          <= '0;
      y1_q          <= '0;
      colour_q      <= '0;
      uv_a_q        <= '0;
      uv_b_q        <= '0;
      slot_q        <= '0;
      flush_item_q  <= 1'b0;
      flush_q       <= 1'b0;
      flushed_q     <= '0;
      index_total_q <= '0;
      k_q           <= '0;
      o_q           <= '0;
      launched_q    <= 1'b0;
      vx_q          <= '0;
      vy_q          <= '0;
      vz_q          <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      // output register: loaded by an emit step, emptied by a taken transaction
      if (emit_go) out_valid_q <= 1'b1;
      else if (vert_o.ready) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            px_q         <= sprite_i.data.pos_x;
            py_q         <= sprite_i.data.pos_y;
            pz_q         <= sprite_i.data.pos_z;
            x1_q         <= spq_pkg::sat32(x1_sum);
            y1_q         <= spq_pkg::sat32(y1_sum);
            colour_q     <= sprite_i.data.colour_in;
            uv_a_q       <= sprite_i.data.uv_first;
            uv_b_q       <= sprite_i.data.uv_second;
            k_q          <= '0;
            o_q          <= '0;
            launched_q   <= 1'b0;
            flush_q      <= 1'b0;
            slot_q       <= '0;
            flush_item_q <= sprite_i.data.mode;
            if (sprite_i.data.mode) begin
              flushed_q     <= index_total_q;
              index_total_q <= '0;
              state_q       <= S_EMIT;
            end else if (sprite_i.data.texture_id == '0) begin
              state_q <= S_XFORM;
            end else begin
              state_q <= S_SEARCH;
            end
          end
        end

        S_SEARCH: begin
          if (slot_res.done) begin
            slot_q <= slot_res.slot;
            if (slot_res.flush) begin
              flush_q       <= 1'b1;
              flushed_q     <= index_total_q;
              index_total_q <= '0;
            end
            state_q <= S_XFORM;
          end
        end

        S_XFORM: begin
          if (!launched_q) launched_q <= 1'b1;
          if (xf_res.done) begin
            launched_q <= 1'b0;
            case (o_q)
              2'd0:    vx_q <= xf_res.value;
              2'd1:    vy_q <= xf_res.value;
              default: vz_q <= xf_res.value;
            endcase
            if (o_q == 2'd2) begin
              o_q     <= '0;
              state_q <= S_EMIT;
            end else begin
              o_q <= o_q + 2'd1;
            end
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_q <= emit_data;
            if (flush_item_q) begin
              state_q <= S_IDLE;
            end else if (k_q == 2'd3) begin
              // six indices per sprite, saturating
              index_total_q <= (index_total_q > (spq_pkg::IDX_MAX - spq_pkg::IDX_STEP))
                             ? spq_pkg::IDX_MAX : index_total_q + spq_pkg::IDX_STEP;
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= S_XFORM;
            end
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign vert_o.valid = out_valid_q;
  assign vert_o.data  = out_q;

  // ---------------------------------------------------------------------
  // Sub-units
  // ---------------------------------------------------------------------
  spq_xform u_xform (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (xf_req),
    .res_o  (xf_res)
  );

  spq_slot_table #(
    .MAX_TEXTURES (MAX_TEXTURES)
  ) u_slot_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (slot_req),
    .res_o  (slot_res)
  );

endmodule

### tb/spq_checker.sv
// Vertex checker for the sprite quad batcher: watches the sprite, vertex and
// register write ports, predicts every vertex and compares field by field.
// Depends on spq_pkg and the channel interfaces in spq_if.sv.
module spq_checker #(
  parameter int unsigned TEX_SLOTS = spq_pkg::MAX_TEXTURES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  spq_in_if                              sprite_mon,
  spq_out_if                             vert_mon,
  input  logic                           cfg_we_i,
  input  logic [spq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spq_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [19:0] QUAD_INDICES = 20'd6;
  localparam logic [19:0] INDEX_CEIL   = 20'hFFFFF;

  logic [47:0]        row_x, row_y, row_z;
  logic signed [31:0] offs_x, offs_y, offs_z;
  logic [31:0]        tex_ids [TEX_SLOTS];
  int unsigned        ids_in_use;
  logic [19:0]        batch_indices;
  spq_pkg::spq_out_t  vert_q [$];
  int unsigned        verts_seen;

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Q4.12 row times Q16.16 point, round half up, then saturating offset
  function automatic logic signed [31:0] apply_row(input logic [47:0] row,
                                                    input logic signed [31:0] offs,
                                                    input logic signed [31:0] px,
                                                    input logic signed [31:0] py,
                                                    input logic signed [31:0] pz);
    longint acc;
    acc = longint'($signed(row[15:0]))  * longint'(px)
        + longint'($signed(row[31:16])) * longint'(py)
        + longint'($signed(row[47:32])) * longint'(pz);
    acc = (acc + 64'sd2048) >>> 12;
    return clip32(acc + longint'(offs));
  endfunction

  function automatic void drop_batch();
    ids_in_use    = 0;
    batch_indices = '0;
  endfunction

  // expected vertices wait at the tail of the queue
  function automatic void expect_vertex(input spq_pkg::spq_out_t v);
    vert_q.insert(vert_q.size(), v);
  endfunction

  function automatic void predict_flush();
    spq_pkg::spq_out_t v;
    v                 = '0;
    v.flush_batch     = 1'b1;
    v.flushed_indices = batch_indices;
    v.last            = 1'b1;
    expect_vertex(v);
    drop_batch();
  endfunction

  function automatic void predict_quad(input spq_pkg::spq_in_t s);
    logic signed [31:0] x1, y1;
    logic signed [31:0] cx [4];
    logic signed [31:0] cy [4];
    logic [31:0]        uvp [4];
    logic [5:0]         slot_no;
    logic               flushed_now;
    logic [19:0]        flushed_cnt;
    logic               hit;
    spq_pkg::spq_out_t  v;
    x1          = clip32(longint'(s.pos_x) + longint'(s.size_w));
    y1          = clip32(longint'(s.pos_y) + longint'(s.size_h));
    slot_no     = '0;
    flushed_now = 1'b0;
    flushed_cnt = '0;
    hit         = 1'b0;
    if (s.texture_id != '0) begin
      for (int i = 0; i < ids_in_use; i++) begin
        if (tex_ids[i] == s.texture_id) begin
          slot_no = 6'(i + 1);
          hit     = 1'b1;
          break;
        end
      end
      if (!hit) begin
        // table full: the batch goes out ahead of this sprite
        if (ids_in_use >= TEX_SLOTS) begin
          flushed_now = 1'b1;
          flushed_cnt = batch_indices;
          drop_batch();
        end
        tex_ids[ids_in_use] = s.texture_id;
        ids_in_use++;
        slot_no = 6'(ids_in_use);
      end
    end
    cx  = '{s.pos_x, s.pos_x, x1, x1};
    cy  = '{s.pos_y, y1, y1, s.pos_y};
    uvp = '{s.uv_first[31:0], s.uv_first[63:32], s.uv_second[31:0], s.uv_second[63:32]};
    for (int k = 0; k < 4; k++) begin
      v.vert_x          = apply_row(row_x, offs_x, cx[k], cy[k], s.pos_z);
      v.vert_y          = apply_row(row_y, offs_y, cx[k], cy[k], s.pos_z);
      v.vert_z          = apply_row(row_z, offs_z, cx[k], cy[k], s.pos_z);
      v.tex_u           = uvp[k][15:0];
      v.tex_v           = uvp[k][31:16];
      v.tex_slot        = slot_no;
      v.colour_out      = s.colour_in;
      v.flush_batch     = (k == 0) && flushed_now;
      v.flushed_indices = (k == 0) ? flushed_cnt : '0;
      v.last            = (k == 3);
      expect_vertex(v);
    end
    batch_indices = (batch_indices > INDEX_CEIL - QUAD_INDICES) ? INDEX_CEIL
                                                                : batch_indices + QUAD_INDICES;
  endfunction

  function automatic void note_fail(input string msg);
    fail_count_o++;
    if (fail_count_o <= 10) $display("[%0t] vertex %0d: %s", $time, verts_seen, msg);
  endfunction

  function automatic void check_field(input string field, input logic [63:0] got,
                                      input logic [63:0] want);
    if (got !== want) note_fail($sformatf("%s expected %h got %h", field, want, got));
  endfunction

  function automatic void check_vertex(input spq_pkg::spq_out_t got);
    spq_pkg::spq_out_t want;
    if (vert_q.size() == 0) begin
      note_fail("vertex transaction with nothing pending");
      return;
    end
    want = vert_q.pop_front();
    check_field("vert_x", got.vert_x, want.vert_x);
    check_field("vert_y", got.vert_y, want.vert_y);
    check_field("vert_z", got.vert_z, want.vert_z);
    check_field("tex_u", got.tex_u, want.tex_u);
    check_field("tex_v", got.tex_v, want.tex_v);
    check_field("tex_slot", got.tex_slot, want.tex_slot);
    check_field("colour_out", got.colour_out, want.colour_out);
    check_field("flush_batch", got.flush_batch, want.flush_batch);
    check_field("flushed_indices", got.flushed_indices, want.flushed_indices);
    check_field("last", got.last, want.last);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // identity matrix, no offset, empty batch
      row_x         = 48'h0000_0000_1000;
      row_y         = 48'h0000_1000_0000;
      row_z         = 48'h1000_0000_0000;
      offs_x        = '0;
      offs_y        = '0;
      offs_z        = '0;
      drop_batch();
      vert_q.delete();
      verts_seen    = 0;
      fail_count_o  = 0;
      outstanding_o = 0;
    end else begin
      if (vert_mon.valid && vert_mon.ready) begin
        check_vertex(vert_mon.data);
        verts_seen++;
      end
      if (sprite_mon.valid && sprite_mon.ready) begin
        if (sprite_mon.data.mode) predict_flush();
        else predict_quad(sprite_mon.data);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          spq_pkg::CFG_ROW_X:   row_x  = cfg_data_i;
          spq_pkg::CFG_ROW_Y:   row_y  = cfg_data_i;
          spq_pkg::CFG_ROW_Z:   row_z  = cfg_data_i;
          spq_pkg::CFG_TRANS_X: offs_x = cfg_data_i[31:0];
          spq_pkg::CFG_TRANS_Y: offs_y = cfg_data_i[31:0];
          spq_pkg::CFG_TRANS_Z: offs_z = cfg_data_i[31:0];
          default: ;
        endcase
      end
      outstanding_o = vert_q.size();
    end
  end

endmodule

### tb/tb_sprite_quad_batcher.sv
// Top of the sprite quad batcher testbench: clock, reset, sprite stimulus,
// register writes and vertex back-pressure; verdict from spq_checker.
// Depends on spq_pkg, spq_if.sv, spq_checker.sv and the block itself.
module tb_sprite_quad_batcher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TEX_SLOTS   = spq_pkg::MAX_TEXTURES_DEF;
  localparam int unsigned IDX_W       = spq_pkg::CFG_IDX_W;
  localparam int unsigned DATA_W      = spq_pkg::CFG_DATA_W;
  localparam int unsigned POOL_SIZE   = 48;      // more ids than slots, so tables fill
  localparam int unsigned DRAIN_WAIT  = 150;     // one sprite worst case, full table
  localparam int unsigned HOLD_CYCLES = 800;     // long vertex stall, fills the block
  localparam longint      RUN_LIMIT   = 5_000_000;

  // receiver back-pressure styles, each held for a random window before switching
  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_COMB, RX_CHOKE} rx_mode_e;

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i;
  logic [IDX_W-1:0]  cfg_idx_i;
  logic [DATA_W-1:0] cfg_data_i;
  int                fail_count;
  int                outstanding;

  logic [31:0] tid_pool [POOL_SIZE];
  int unsigned burst_left;
  int unsigned hold_requests;

  spq_in_if  sprite_ch ();
  spq_out_if vert_ch ();

  sprite_quad_batcher #(.MAX_TEXTURES(TEX_SLOTS)) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sprite_i   (sprite_ch),
    .vert_o     (vert_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  spq_checker #(.TEX_SLOTS(TEX_SLOTS)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sprite_mon    (sprite_ch),
    .vert_mon      (vert_ch),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always #5 clk_i = ~clk_i;

  // Q16.16 operand: half full random, the other half the rails,
  // zero and small signed values so corner sums and products saturate too
  function automatic logic [31:0] pick_q16();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return {{12{r[19]}}, r[19:0]};
      default: return r;
    endcase
  endfunction

  // full-width random register value
  function automatic logic [DATA_W-1:0] rand_reg();
    return DATA_W'({$urandom(), $urandom()});
  endfunction

  // One random transaction. Texture ids: some untextured, many from a pool a
  // bit larger than the slot table (hits and overflows), the rest fresh.
  function automatic spq_pkg::spq_in_t pick_item(input int unsigned flush_pct);
    spq_pkg::spq_in_t it;
    int unsigned roll;
    it.mode       = ($urandom_range(0, 99) < flush_pct);
    it.pos_x      = pick_q16();
    it.pos_y      = pick_q16();
    it.pos_z      = pick_q16();
    it.size_w     = pick_q16();
    it.size_h     = pick_q16();
    it.colour_in  = $urandom();
    it.uv_first   = {$urandom(), $urandom()};
    it.uv_second  = {$urandom(), $urandom()};
    roll          = $urandom_range(0, 9);
    if (roll < 2)      it.texture_id = '0;
    else if (roll < 6) it.texture_id = tid_pool[$urandom_range(0, POOL_SIZE - 1)];
    else               it.texture_id = $urandom();
    return it;
  endfunction

  function automatic spq_pkg::spq_in_t quad(input logic [31:0] px, input logic [31:0] py,
                                            input logic [31:0] pz, input logic [31:0] w,
                                            input logic [31:0] h, input logic [31:0] tid);
    spq_pkg::spq_in_t it;
    it            = pick_item(0);
    it.mode       = 1'b0;
    it.pos_x      = px;
    it.pos_y      = py;
    it.pos_z      = pz;
    it.size_w     = w;
    it.size_h     = h;
    it.texture_id = tid;
    return it;
  endfunction

  // Sender: bursts of back-to-back transactions, random gaps between bursts.
  // Valid stays high across a burst, so it is never dropped and raised in one step.
  task automatic send_sprite(input spq_pkg::spq_in_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 3);
      if (gap > 0) begin
        @(negedge clk_i);
        sprite_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    sprite_ch.valid <= 1'b1;
    sprite_ch.data  <= it;
    do @(posedge clk_i); while (!sprite_ch.ready);
    burst_left--;
  endtask

  task automatic send_random(input int unsigned count, input int unsigned flush_pct);
    for (int i = 0; i < count; i++) send_sprite(pick_item(flush_pct));
  endtask

  // Drop valid and wait until every predicted vertex has come out.
  // Sampled at the falling edge, after the checker has seen the rising one.
  task automatic settle();
    @(negedge clk_i);
    sprite_ch.valid <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [47:0] mild_row();
    return {16'($urandom_range(0, 16'h3FFF) - 16'h2000),
            16'($urandom_range(0, 16'h3FFF) - 16'h2000),
            16'($urandom_range(0, 16'h3FFF) - 16'h2000)};
  endfunction

  // Receiver: ready changes at the falling edge. A hold-off request from the
  // stimulus side makes it refuse vertices for HOLD_CYCLES, counted here.
  initial begin
    rx_mode_e    rx_mode;
    int unsigned rx_window;
    int unsigned rx_tick;
    int unsigned hold_left;
    int unsigned holds_served;
    rx_mode       = RX_FREE;
    rx_window     = 0;
    rx_tick       = 0;
    hold_left     = 0;
    holds_served  = 0;
    vert_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rx_tick++;
      if (hold_requests > holds_served) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        vert_ch.ready <= 1'b0;
      end else begin
        if (rx_window == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 3));
          rx_window = $urandom_range(20, 120);
        end
        rx_window--;
        case (rx_mode)
          RX_FREE:   vert_ch.ready <= 1'b1;
          RX_RANDOM: vert_ch.ready <= ($urandom_range(0, 2) != 0);
          RX_COMB:   vert_ch.ready <= (rx_tick % 4 != 3);
          RX_CHOKE:  vert_ch.ready <= ($urandom_range(0, 4) == 0);
          default:   vert_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    spq_pkg::spq_in_t it;
    // every block input known from time zero
    sprite_ch.valid = 1'b0;
    sprite_ch.data  = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    burst_left      = 0;
    hold_requests   = 0;
    // distinct nonzero ids: the low byte is the pool position plus one
    for (int i = 0; i < POOL_SIZE; i++) tid_pool[i] = ($urandom() & 32'hFFFF_FF00) | 32'(i + 1);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed transactions, identity transform after reset ----
    send_sprite(quad('0, '0, '0, '0, '0, '0));
    // corner sums saturate high, then low; then mixed signs that cancel
    send_sprite(quad(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, '0));
    send_sprite(quad(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, '0));
    it = quad(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '0);
    it.colour_in = '1;
    it.uv_first  = '1;
    it.uv_second = '1;
    send_sprite(it);
    // texture slots: new id, same id again, second id, first id again
    send_sprite(quad(32'h0001_0000, 32'h0002_0000, '0, 32'h0010_0000, 32'h0008_0000,
                     tid_pool[0]));
    send_sprite(quad(32'hFFFF_0000, 32'h0000_8000, 32'h0004_0000, 32'h0000_0001,
                     32'hFFFF_FFFF, tid_pool[0]));
    send_sprite(quad(pick_q16(), pick_q16(), pick_q16(), pick_q16(), pick_q16(), tid_pool[1]));
    send_sprite(quad(pick_q16(), pick_q16(), pick_q16(), pick_q16(), pick_q16(), tid_pool[0]));
    // flush of a batch in use, then of an empty batch; payload is ignored
    it = pick_item(0);
    it.mode = 1'b1;
    send_sprite(it);
    it = '0;
    it.mode = 1'b1;
    send_sprite(it);
    send_sprite(quad(pick_q16(), pick_q16(), pick_q16(), pick_q16(), pick_q16(), tid_pool[1]));
    send_sprite(quad(pick_q16(), pick_q16(), pick_q16(), pick_q16(), pick_q16(), '1));
    it = '1;
    send_sprite(it);
    settle();

    // ---- random transform, unused register indexes written too ----
    write_reg(spq_pkg::CFG_ROW_X, rand_reg());
    write_reg(spq_pkg::CFG_ROW_Y, rand_reg());
    write_reg(spq_pkg::CFG_ROW_Z, rand_reg());
    write_reg(spq_pkg::CFG_TRANS_X, rand_reg());
    write_reg(spq_pkg::CFG_TRANS_Y, rand_reg());
    write_reg(spq_pkg::CFG_TRANS_Z, rand_reg());
    write_reg(IDX_W'(spq_pkg::CFG_TRANS_Z + 1), rand_reg());
    write_reg(IDX_W'(spq_pkg::CFG_TRANS_Z + 2), rand_reg());
    send_random(90, 3);
    settle();

    // ---- extreme coefficients and offsets; long vertex stall meanwhile ----
    write_reg(spq_pkg::CFG_ROW_X, 48'h8000_8000_8000);
    write_reg(spq_pkg::CFG_ROW_Y, 48'h8000_7FFF_8000);
    write_reg(spq_pkg::CFG_ROW_Z, 48'h7FFF_7FFF_7FFF);
    write_reg(spq_pkg::CFG_TRANS_X, {16'hFFFF, 32'h7FFF_FFFF});
    write_reg(spq_pkg::CFG_TRANS_Y, {16'h0000, 32'h8000_0000});
    write_reg(spq_pkg::CFG_TRANS_Z, '0);
    hold_requests++;
    send_random(60, 3);
    settle();

    // ---- mild transform; fill the slot table past full ----
    write_reg(spq_pkg::CFG_ROW_X, mild_row());
    write_reg(spq_pkg::CFG_ROW_Y, mild_row());
    write_reg(spq_pkg::CFG_ROW_Z, mild_row());
    write_reg(spq_pkg::CFG_TRANS_X, rand_reg());
    write_reg(spq_pkg::CFG_TRANS_Y, rand_reg());
    write_reg(spq_pkg::CFG_TRANS_Z, rand_reg());
    it = pick_item(0);
    it.mode = 1'b1;
    send_sprite(it);
    // mostly new ids with a repeat of an earlier id every fourth sprite; the 33rd new id overflows
    for (int i = 0; i < 46; i++) begin
      it = pick_item(0);
      it.texture_id = (i % 4 == 3) ? tid_pool[i - 2] : tid_pool[i];
      send_sprite(it);
    end
    send_random(50, 2);
    settle();

    // ---- zero matrix: every vertex is the offset alone ----
    write_reg(spq_pkg::CFG_ROW_X, '0);
    write_reg(spq_pkg::CFG_ROW_Y, '0);
    write_reg(spq_pkg::CFG_ROW_Z, '0);
    write_reg(spq_pkg::CFG_TRANS_X, rand_reg());
    write_reg(spq_pkg::CFG_TRANS_Y, {16'h0000, 32'h7FFF_FFFF});
    write_reg(spq_pkg::CFG_TRANS_Z, {16'hFFFF, 32'h8000_0000});
    send_random(30, 5);
    settle();

    // stray vertices after the last one would show up in the checker here
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sprite_quad_batcher.f
hdl/spq_pkg.sv
hdl/spq_if.sv
hdl/spq_xform.sv
hdl/spq_slot_table.sv
hdl/sprite_quad_batcher.sv
tb/spq_checker.sv
tb/tb_sprite_quad_batcher.sv
